### rtl/crsha_pkg.sv
// Shared types and constants for the CAN reply scheduler.
package crsha_pkg;
  localparam int RX_DEPTH  = 4;
  localparam int HIT_DEPTH = 4;
  localparam int RX_AW  = $clog2(RX_DEPTH);
  localparam int HIT_AW = (HIT_DEPTH > 1) ? $clog2(HIT_DEPTH) : 1;
  localparam int HIT_CW = $clog2(HIT_DEPTH + 1);

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_HIT   = 2'd1;
  localparam logic [1:0] REQ_FRAME = 2'd2;
  localparam logic [1:0] REQ_FAULT = 2'd3;

  localparam logic [2:0] RXK_STATUS = 3'd1;
  localparam logic [2:0] RXK_NODEID = 3'd2;
  localparam logic [2:0] RXK_LED    = 3'd3;
  localparam logic [2:0] RXK_ACK    = 3'd4;

  localparam logic [2:0] TXK_NONE   = 3'd0;
  localparam logic [2:0] TXK_RESET  = 3'd1;
  localparam logic [2:0] TXK_INIT   = 3'd2;
  localparam logic [2:0] TXK_STATUS = 3'd3;
  localparam logic [2:0] TXK_NODEID = 3'd4;
  localparam logic [2:0] TXK_ACK    = 3'd5;
  localparam logic [2:0] TXK_FAULT  = 3'd6;
  localparam logic [2:0] TXK_HIT    = 3'd7;

  localparam logic [2:0] REG_CAUSE = 3'd0;
  localparam logic [2:0] REG_FAULT = 3'd1;
  localparam logic [2:0] REG_INIT  = 3'd2;
  localparam logic [2:0] REG_COMM  = 3'd3;
  localparam logic [2:0] REG_HIT   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ENQ, ST_TICK, ST_DRAIN, ST_LOW, ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic        node_ready;
    logic        node_task_busy;
    logic [15:0] fault_map;
    logic        tx_ok;
    logic [2:0]  rx_kind;
    logic [3:0]  rx_dlc;
    logic [7:0]  rx_first_byte;
    logic        rx_all_zero;
    logic        led_accepted;
    logic [55:0] hit_payload;
  } req_t;

  typedef struct packed {
    logic [2:0]  tx_kind;
    logic [63:0] tx_payload;
    logic        comm_lost;
    logic        rx_dropped;
    logic        hit_dropped;
    logic [2:0]  hits_pending;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  cause;
    logic [15:0] fault_period;
    logic [15:0] init_period;
    logic [15:0] comm_period;
    logic [15:0] hit_period;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture input transaction
    logic enq;    // ring updates, comm loss
    logic top;    // reset/init decisions
    logic drain;  // pop one rx entry
    logic low;    // fault/hit decisions
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic done_top;   // tick finished after top stage
    logic rx_empty;
    logic drain_hit;  // popped entry gave a reply
  } sts_t;
endpackage

### rtl/crsha_if.sv
// Valid/ready channel interface.
interface crsha_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/crsha_ctrl.sv
// Sequencing state machine.
module crsha_ctrl import crsha_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_ENQ;
      ST_ENQ:   state_next = sts.is_tick ? ST_TICK : ST_OUT;
      ST_TICK:  state_next = sts.done_top ? ST_OUT : ST_DRAIN;
      ST_DRAIN: begin
        if (sts.rx_empty) state_next = ST_LOW;
        else if (sts.drain_hit) state_next = ST_OUT;
      end
      ST_LOW:   state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE:  begin in_ready = 1'b1; cmd.load = in_valid; end
      ST_ENQ:   cmd.enq = 1'b1;
      ST_TICK:  cmd.top = 1'b1;
      ST_DRAIN: cmd.drain = !sts.rx_empty;
      ST_LOW:   cmd.low = 1'b1;
      ST_OUT:   out_valid = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  a_one_hs: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output both open");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_ENQ) else $error("load lost");
endmodule

### rtl/crsha_dp.sv
// Rings, timers and frame selection datapath.
module crsha_dp import crsha_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  req_t req_in,
  input  cfg_t cfg,
  output sts_t sts,
  output rsp_t rsp
);
  req_t r;
  logic [11:0] rx_ring [RX_DEPTH];
  logic [63:0] hit_ring [HIT_DEPTH];
  logic [RX_AW-1:0] rx_wp, rx_rp;
  logic [HIT_AW-1:0] hit_wp, hit_rp;
  logic [HIT_CW-1:0] hit_cnt;
  logic [7:0] hit_seq;
  logic [31:0] at_time [4];
  logic [3:0] at_valid;
  logic [31:0] last_fault_time, last_req_time;
  logic [15:0] last_fault;
  logic init_pend, reset_pend, attempted;
  logic [2:0] kind;
  logic [63:0] payload;
  logic lost, rx_drop, hit_drop;

  function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] p);
    return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction
  function automatic logic [HIT_AW-1:0] hit_inc(input logic [HIT_AW-1:0] p);
    return (p == HIT_AW'(HIT_DEPTH - 1)) ? '0 : HIT_AW'(p + 1'b1);
  endfunction

  logic [3:0] exp_t;
  always_comb begin
    for (int i = 0; i < 4; i++) exp_t[i] = !at_valid[i];
    if (r.now_ms - at_time[0] >= {16'd0, cfg.init_period}) exp_t[0] = 1'b1;
    if (r.now_ms - at_time[1] >= {16'd0, cfg.init_period}) exp_t[1] = 1'b1;
    if (r.now_ms - at_time[2] >= {16'd0, cfg.fault_period}) exp_t[2] = 1'b1;
    if (r.now_ms - at_time[3] >= {16'd0, cfg.hit_period}) exp_t[3] = 1'b1;
  end

  logic fvalid;
  always_comb begin
    unique case (r.rx_kind)
      RXK_STATUS: fvalid = (r.rx_dlc == 4'd0) || (r.rx_dlc == 4'd8 && r.rx_all_zero);
      RXK_NODEID: fvalid = r.rx_dlc == 4'd0;
      RXK_LED:    fvalid = r.rx_dlc == 4'd8;
      RXK_ACK:    fvalid = r.rx_dlc == 4'd1;
      default:    fvalid = 1'b0;
    endcase
  end

  logic [11:0] rx_e;
  logic rx_reply;
  logic [2:0] rx_reply_kind;
  assign rx_e = rx_ring[rx_rp];
  always_comb begin
    rx_reply = 1'b1;
    rx_reply_kind = TXK_NONE;
    case (rx_e[2:0])
      RXK_STATUS: rx_reply_kind = TXK_STATUS;
      RXK_NODEID: rx_reply_kind = TXK_NODEID;
      RXK_LED:    if (rx_e[3]) rx_reply_kind = TXK_ACK; else rx_reply = 1'b0;
      default:    rx_reply = 1'b0;
    endcase
  end

  logic fault_want;
  assign fault_want = (r.fault_map != last_fault) ||
    (r.fault_map != 16'd0 && (r.now_ms - last_fault_time >= {16'd0, cfg.fault_period}));

  // top stage decisions, seen by the controller in the same cycle
  logic top_reset, top_init;
  assign top_reset = reset_pend && cfg.cause != 8'd0 && exp_t[0];
  assign top_init  = !attempted && init_pend && exp_t[1];

  assign sts.is_tick   = r.req_type == REQ_TICK && r.node_ready;
  assign sts.done_top  = attempted || top_reset || top_init;
  assign sts.rx_empty  = rx_rp == rx_wp;
  assign sts.drain_hit = rx_reply;

  always_ff @(posedge clk) begin
    if (cmd.load) r <= req_in;
    if (cmd.enq) begin
      kind <= TXK_NONE;
      payload <= '0;
      attempted <= r.node_task_busy;
      rx_drop <= 1'b0;
      hit_drop <= 1'b0;
      lost <= (r.now_ms - last_req_time) > {16'd0, cfg.comm_period};
      if (r.req_type == REQ_HIT) begin
        if (hit_cnt >= HIT_CW'(HIT_DEPTH)) hit_drop <= 1'b1;
        else hit_ring[hit_wp] <= {r.hit_payload, hit_seq};
      end else if (r.req_type == REQ_FRAME && r.node_ready && fvalid) begin
        lost <= 1'b0;
        if (rx_inc(rx_wp) == rx_rp) rx_drop <= 1'b1;
        else rx_ring[rx_wp] <= {r.rx_first_byte, r.led_accepted, r.rx_kind};
      end
    end
    if (cmd.top) begin
      if (top_reset) begin
        kind <= TXK_RESET;
        payload <= {56'd0, cfg.cause};
        attempted <= 1'b1;
      end else if (top_init) begin
        kind <= TXK_INIT;
        attempted <= 1'b1;
      end
    end
    if (cmd.drain && rx_reply) kind <= rx_reply_kind;
    if (cmd.low) begin
      if (fault_want && exp_t[2]) begin
        kind <= TXK_FAULT;
        payload <= {48'd0, r.fault_map};
      end else if (hit_cnt != '0 && exp_t[3]) begin
        kind <= TXK_HIT;
        payload <= hit_ring[hit_rp];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_wp <= '0; rx_rp <= '0; hit_wp <= '0; hit_rp <= '0;
      hit_cnt <= '0; hit_seq <= '0; at_valid <= '0;
      for (int i = 0; i < 4; i++) at_time[i] <= '0;
      last_fault_time <= '0; last_req_time <= '0; last_fault <= 16'hFFFF;
      init_pend <= 1'b1; reset_pend <= 1'b1;
    end else begin
      if (cmd.enq) begin
        if (r.req_type == REQ_HIT && hit_cnt < HIT_CW'(HIT_DEPTH)) begin
          hit_seq <= hit_seq + 8'd1;
          hit_wp <= hit_inc(hit_wp);
          hit_cnt <= hit_cnt + 1'b1;
        end else if (r.req_type == REQ_FRAME && r.node_ready && fvalid) begin
          last_req_time <= r.now_ms;
          if (rx_inc(rx_wp) != rx_rp) rx_wp <= rx_inc(rx_wp);
        end else if (r.req_type == REQ_FAULT) begin
          last_fault <= 16'hFFFF;
        end
      end
      if (cmd.top) begin
        if (top_reset) begin
          at_time[0] <= r.now_ms; at_valid[0] <= 1'b1;
          if (r.tx_ok) reset_pend <= 1'b0;
        end else if (top_init) begin
          at_time[1] <= r.now_ms; at_valid[1] <= 1'b1;
          if (r.tx_ok) init_pend <= 1'b0;
        end
      end
      if (cmd.drain) begin
        rx_rp <= rx_inc(rx_rp);
        if (rx_e[2:0] == RXK_ACK && hit_cnt != '0 && rx_e[11:4] == hit_ring[hit_rp][7:0]) begin
          hit_rp <= hit_inc(hit_rp);
          hit_cnt <= hit_cnt - 1'b1;
        end
      end
      if (cmd.low) begin
        if (fault_want && exp_t[2]) begin
          at_time[2] <= r.now_ms; at_valid[2] <= 1'b1;
          if (r.tx_ok) begin
            last_fault <= r.fault_map;
            last_fault_time <= r.now_ms;
          end
        end else if (hit_cnt != '0 && exp_t[3]) begin
          at_time[3] <= r.now_ms; at_valid[3] <= 1'b1;
        end
      end
    end
  end

  assign rsp.tx_kind = kind;
  assign rsp.tx_payload = payload;
  assign rsp.comm_lost = lost;
  assign rsp.rx_dropped = rx_drop;
  assign rsp.hit_dropped = hit_drop;
  assign rsp.hits_pending = 3'(hit_cnt);

  a_cnt: assert property (@(posedge clk) disable iff (rst) hit_cnt <= HIT_CW'(HIT_DEPTH))
    else $error("hit count overflow");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.drain |-> rx_rp != rx_wp) else $error("drain of empty ring");
  a_ptr: assert property (@(posedge clk) disable iff (rst)
    (hit_cnt == '0) |-> hit_rp == hit_wp) else $error("hit pointers out of step");
endmodule

### rtl/can_reply_scheduler_hit_ack_top.sv
// Top level of the CAN reply scheduler with hit acknowledge.
// Sequence after accept: ENQ, then OUT for a non-tick or a node not ready; a tick goes
//   ENQ, TICK, then OUT if reset/init or a busy node layer settles it, else DRAIN (a pop
//   with a reply goes to OUT; an empty ring goes to LOW, the fault/hit stage, then OUT); one rx ring pop per cycle.
// One transaction at a time: a new request is taken only after the result is taken at the output.
// Reset (rst, sync): rings empty, timers expired, init/reset pending, regs 0/100/500/300/100.
module can_reply_scheduler_hit_ack_top import crsha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  crsha_if.sink       req,
  crsha_if.source     rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  rsp_t rsp_d;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  // register write on access phase; addresses not 4-aligned still map by [4:2]
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{cause: 8'd0, fault_period: 16'd100, init_period: 16'd500,
               comm_period: 16'd300, hit_period: 16'd100};
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_CAUSE: cfg.cause <= pwdata[7:0];
        REG_FAULT: cfg.fault_period <= pwdata[15:0];
        REG_INIT:  cfg.init_period <= pwdata[15:0];
        REG_COMM:  cfg.comm_period <= pwdata[15:0];
        REG_HIT:   cfg.hit_period <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_CAUSE: prdata = {24'd0, cfg.cause};
      REG_FAULT: prdata = {16'd0, cfg.fault_period};
      REG_INIT:  prdata = {16'd0, cfg.init_period};
      REG_COMM:  prdata = {16'd0, cfg.comm_period};
      REG_HIT:   prdata = {16'd0, cfg.hit_period};
      default:   prdata = '0;
    endcase
  end

  crsha_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .sts, .cmd
  );

  crsha_dp u_dp (
    .clk, .rst, .cmd, .req_in(req.data), .cfg, .sts, .rsp(rsp_d)
  );

  assign rsp.data = rsp_d;
endmodule

### sim/crsha_scoreboard.sv
// Scoreboard for the CAN reply scheduler: tracks config, predicts each response, compares.
`timescale 1ns / 1ps
module crsha_scoreboard import crsha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  req_t        req_data,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  rsp_t        rsp_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          outstanding,
  output logic [7:0]  oldest_seq
);
  localparam int TMR_RESET = 0;
  localparam int TMR_INIT  = 1;
  localparam int TMR_FAULT = 2;
  localparam int TMR_HIT   = 3;

  cfg_t        cfg;
  logic [11:0] rx_q [RX_DEPTH];
  int unsigned rx_wr, rx_rd;
  logic [63:0] hit_q [HIT_DEPTH];
  int unsigned hit_wr, hit_rd, hit_cnt;
  logic [7:0]  hit_seq;
  logic [31:0] tmr_at [4];
  bit          tmr_ok [4];
  logic [31:0] fault_sent_at, last_req_at;
  logic [15:0] fault_sent;
  bit          init_pend, reset_pend;
  rsp_t        pending_q [$];
  int          err_cnt;

  assign errors      = err_cnt;
  assign outstanding = pending_q.size();
  assign oldest_seq  = hit_q[hit_rd][7:0];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  function automatic bit timer_due(int w, logic [31:0] now, logic [15:0] per);
    logic [31:0] d;
    d = now - tmr_at[w];
    return !tmr_ok[w] || (d >= {16'd0, per});
  endfunction

  function automatic void timer_mark(int w, logic [31:0] now);
    tmr_at[w] = now;
    tmr_ok[w] = 1'b1;
  endfunction

  function automatic bit frame_ok(logic [2:0] kind, logic [3:0] dlc, logic zero);
    case (kind)
      RXK_STATUS: return dlc == 4'd0 || (dlc == 4'd8 && zero);
      RXK_NODEID: return dlc == 4'd0;
      RXK_LED:    return dlc == 4'd8;
      RXK_ACK:    return dlc == 4'd1;
      default:    return 1'b0;
    endcase
  endfunction

  // pops rx entries until one needs a reply; matching acks retire the oldest hit
  function automatic logic [2:0] drain_replies();
    logic [11:0] e;
    while (rx_rd != rx_wr) begin
      e = rx_q[rx_rd];
      rx_rd = (rx_rd + 1) % RX_DEPTH;
      if (e[2:0] == RXK_STATUS) return TXK_STATUS;
      if (e[2:0] == RXK_NODEID) return TXK_NODEID;
      if (e[2:0] == RXK_LED && e[3]) return TXK_ACK;
      if (e[2:0] == RXK_ACK && hit_cnt != 0 && e[11:4] == hit_q[hit_rd][7:0]) begin
        hit_rd = (hit_rd + 1) % HIT_DEPTH;
        hit_cnt--;
      end
    end
    return TXK_NONE;
  endfunction

  function automatic rsp_t schedule_frame(req_t r);
    rsp_t        o;
    logic [31:0] age;
    logic [2:0]  k;
    bit          sent;
    int unsigned nxt;
    o = '0;
    if (r.req_type == REQ_HIT) begin
      if (hit_cnt >= HIT_DEPTH) o.hit_dropped = 1'b1;
      else begin
        hit_q[hit_wr] = {r.hit_payload, hit_seq};
        hit_seq++;
        hit_wr = (hit_wr + 1) % HIT_DEPTH;
        hit_cnt++;
      end
    end else if (r.req_type == REQ_FRAME) begin
      if (r.node_ready && frame_ok(r.rx_kind, r.rx_dlc, r.rx_all_zero)) begin
        nxt = (rx_wr + 1) % RX_DEPTH;
        last_req_at = r.now_ms;
        if (nxt == rx_rd) o.rx_dropped = 1'b1;
        else begin
          rx_q[rx_wr] = {r.rx_first_byte, r.led_accepted, r.rx_kind};
          rx_wr = nxt;
        end
      end
    end else if (r.req_type == REQ_FAULT) begin
      fault_sent = 16'hFFFF;
    end
    age = r.now_ms - last_req_at;
    o.comm_lost = age > {16'd0, cfg.comm_period};
    if (r.req_type == REQ_TICK && r.node_ready) begin
      sent = r.node_task_busy;
      if (reset_pend && cfg.cause != 8'd0 && timer_due(TMR_RESET, r.now_ms, cfg.init_period)) begin
        timer_mark(TMR_RESET, r.now_ms);
        if (r.tx_ok) reset_pend = 1'b0;
        o.tx_kind = TXK_RESET;
        o.tx_payload = {56'd0, cfg.cause};
        sent = 1'b1;
      end
      if (!sent && init_pend && timer_due(TMR_INIT, r.now_ms, cfg.init_period)) begin
        timer_mark(TMR_INIT, r.now_ms);
        if (r.tx_ok) init_pend = 1'b0;
        o.tx_kind = TXK_INIT;
        sent = 1'b1;
      end
      if (!sent) begin
        k = drain_replies();
        if (k != TXK_NONE) begin
          o.tx_kind = k;
          sent = 1'b1;
        end
      end
      age = r.now_ms - fault_sent_at;
      if (!sent && (r.fault_map != fault_sent ||
          (r.fault_map != 16'd0 && age >= {16'd0, cfg.fault_period})) &&
          timer_due(TMR_FAULT, r.now_ms, cfg.fault_period)) begin
        timer_mark(TMR_FAULT, r.now_ms);
        if (r.tx_ok) begin
          fault_sent = r.fault_map;
          fault_sent_at = r.now_ms;
        end
        o.tx_kind = TXK_FAULT;
        o.tx_payload = {48'd0, r.fault_map};
        sent = 1'b1;
      end
      if (!sent && hit_cnt != 0 && timer_due(TMR_HIT, r.now_ms, cfg.hit_period)) begin
        timer_mark(TMR_HIT, r.now_ms);
        o.tx_kind = TXK_HIT;
        o.tx_payload = hit_q[hit_rd];
      end
    end
    o.hits_pending = (hit_cnt > 7) ? 3'd7 : hit_cnt[2:0];
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      cfg <= '{cause: 8'd0, fault_period: 16'd100, init_period: 16'd500,
               comm_period: 16'd300, hit_period: 16'd100};
      rx_wr = 0; rx_rd = 0; hit_wr = 0; hit_rd = 0; hit_cnt = 0; hit_seq = 8'd0;
      for (int i = 0; i < 4; i++) begin
        tmr_at[i] = '0;
        tmr_ok[i] = 1'b0;
      end
      for (int i = 0; i < HIT_DEPTH; i++) hit_q[i] = '0;
      fault_sent_at = '0;
      last_req_at = '0;
      fault_sent = 16'hFFFF;
      init_pend = 1'b1;
      reset_pend = 1'b1;
      pending_q.delete();
      err_cnt = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_CAUSE: cfg.cause        <= pwdata[7:0];
          REG_FAULT: cfg.fault_period <= pwdata[15:0];
          REG_INIT:  cfg.init_period  <= pwdata[15:0];
          REG_COMM:  cfg.comm_period  <= pwdata[15:0];
          REG_HIT:   cfg.hit_period   <= pwdata[15:0];
          default: ;
        endcase
      end
      if (req_valid && req_ready) pending_q.push_back(schedule_frame(req_data));
      if (rsp_valid && rsp_ready) begin
        if (pending_q.size() == 0)
          report("unexpected transaction", 64'(rsp_data.tx_kind), 64'd0);
        else begin
          want = pending_q.pop_front();
          if (rsp_data.tx_kind !== want.tx_kind)
            report("tx_kind", 64'(rsp_data.tx_kind), 64'(want.tx_kind));
          if (rsp_data.tx_payload !== want.tx_payload)
            report("tx_payload", rsp_data.tx_payload, want.tx_payload);
          if (rsp_data.comm_lost !== want.comm_lost)
            report("comm_lost", 64'(rsp_data.comm_lost), 64'(want.comm_lost));
          if (rsp_data.rx_dropped !== want.rx_dropped)
            report("rx_dropped", 64'(rsp_data.rx_dropped), 64'(want.rx_dropped));
          if (rsp_data.hit_dropped !== want.hit_dropped)
            report("hit_dropped", 64'(rsp_data.hit_dropped), 64'(want.hit_dropped));
          if (rsp_data.hits_pending !== want.hits_pending)
            report("hits_pending", 64'(rsp_data.hits_pending), 64'(want.hits_pending));
        end
      end
    end
  end
endmodule

### sim/tb_top.sv
// Testbench top: clock, reset, stimulus, register writes and final verdict.
`timescale 1ns / 1ps
module tb_top;
  import crsha_pkg::*;

  localparam int ITEMS_PER_PHASE = 400;
  localparam int WATCHDOG_LIMIT  = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  crsha_if #(.T(req_t)) req_ch ();
  crsha_if #(.T(rsp_t)) rsp_ch ();

  int          errors, outstanding, idle_cycles;
  logic [7:0]  oldest_seq;
  bit          idle_on;      // random gaps/stalls enabled
  logic [31:0] clock_ms;     // running millisecond time fed to the block
  logic [15:0] cur_faults;

  always #5 clk = ~clk;

  can_reply_scheduler_hit_ack_top dut (
    .clk, .rst, .req(req_ch.sink), .rsp(rsp_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  crsha_scoreboard sb (
    .clk, .rst,
    .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
    .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors, .outstanding, .oldest_seq
  );

  // Watchdog: counts cycles with no transaction on either channel or the bus.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // Response side: ready drops for random bursts while idling is enabled.
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Bus write with setup and access phases; the register updates at the access-phase edge.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every expected response has come, then let a tick finish draining.
  task automatic wait_quiet();
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic send(input req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  function automatic req_t base_item(logic [1:0] t);
    req_t r;
    r = '0;
    r.req_type       = t;
    r.now_ms         = clock_ms;
    r.node_ready     = 1'b1;
    r.fault_map      = cur_faults;
    r.tx_ok          = 1'b1;
    r.rx_first_byte  = 8'($urandom);
    r.hit_payload    = 56'({$urandom, $urandom});
    return r;
  endfunction

  function automatic req_t frame_item(logic [2:0] kind, logic [3:0] dlc, logic zero,
                                      logic acc);
    req_t r;
    r = base_item(REQ_FRAME);
    r.rx_kind = kind;
    r.rx_dlc = dlc;
    r.rx_all_zero = zero;
    r.led_accepted = acc;
    return r;
  endfunction

  task automatic tick(input logic ready, input logic busy, input logic ok);
    req_t r;
    r = base_item(REQ_TICK);
    r.node_ready = ready;
    r.node_task_busy = busy;
    r.tx_ok = ok;
    send(r);
  endtask

  // Mostly well-formed traffic with random content, plus some noise.
  task automatic random_item();
    req_t         r;
    int           sel;
    logic [127:0] raw;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 199) == 0) clock_ms = clock_ms + $urandom;
    if (sel < 45) begin
      clock_ms = clock_ms + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 700)
                                                          : $urandom_range(0, 60));
      if ($urandom_range(0, 9) == 0)
        cur_faults = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
      r = base_item(REQ_TICK);
      r.node_ready = $urandom_range(0, 15) != 0;
      r.node_task_busy = $urandom_range(0, 7) == 0;
      r.tx_ok = $urandom_range(0, 4) != 0;
    end else if (sel < 60) begin
      r = base_item(REQ_HIT);
    end else if (sel < 85) begin
      case ($urandom_range(1, 4))
        1: r = frame_item(RXK_STATUS, $urandom_range(0, 1) ? 4'd0 : 4'd8, 1'b1,
                          1'($urandom));
        2: r = frame_item(RXK_NODEID, 4'd0, 1'($urandom), 1'($urandom));
        3: r = frame_item(RXK_LED, 4'd8, 1'($urandom), $urandom_range(0, 3) != 0);
        default: begin
          r = frame_item(RXK_ACK, 4'd1, 1'($urandom), 1'($urandom));
          if ($urandom_range(0, 9) < 7) r.rx_first_byte = oldest_seq;
        end
      endcase
      r.node_ready = $urandom_range(0, 19) != 0;
    end else if (sel < 90) begin
      r = base_item(REQ_FAULT);
    end else begin
      raw = {$urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(req_t)-1:0];
      if ($urandom_range(0, 1)) r.now_ms = clock_ms;
    end
    send(r);
  endtask

  initial begin
    req_t r;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    idle_on = 1'b1;
    clock_ms = 32'd0;
    cur_faults = 16'h0001;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: not ready, busy layer, failed init, frames of every kind, overflows.
    tick(1'b0, 1'b0, 1'b1);
    tick(1'b1, 1'b1, 1'b1);
    tick(1'b1, 1'b0, 1'b0);
    clock_ms = 32'd10;
    tick(1'b1, 1'b0, 1'b1);
    send(frame_item(3'd0, 4'd0, 1'b1, 1'b1));           // unrelated frame
    send(frame_item(RXK_STATUS, 4'd8, 1'b0, 1'b0));     // bad data, ignored
    send(frame_item(3'd7, 4'd15, 1'b1, 1'b1));          // kind beyond the list
    send(frame_item(RXK_STATUS, 4'd8, 1'b1, 1'b0));
    send(frame_item(RXK_LED, 4'd8, 1'b0, 1'b0));        // rejected LED command
    send(frame_item(RXK_NODEID, 4'd0, 1'b0, 1'b0));
    send(frame_item(RXK_LED, 4'd8, 1'b0, 1'b1));        // ring full, dropped
    for (int i = 0; i < 5; i++) begin
      r = base_item(REQ_HIT);
      r.hit_payload = i[0] ? '1 : '0;
      send(r);                                           // fifth one dropped
    end
    r = frame_item(RXK_ACK, 4'd1, 1'b0, 1'b0);
    r.rx_first_byte = 8'hFF;                             // stale ack
    r.node_ready = 1'b0;
    send(r);
    clock_ms = 32'd400;
    cur_faults = 16'hFFFF;
    repeat (3) tick(1'b1, 1'b0, 1'b1);
    send(base_item(REQ_FAULT));
    r = frame_item(RXK_ACK, 4'd1, 1'b0, 1'b0);
    r.rx_first_byte = oldest_seq;
    send(r);
    tick(1'b1, 1'b0, 1'b1);
    tick(1'b1, 1'b0, 1'b1);

    for (int phase = 0; phase < 5; phase++) begin
      if (phase > 0) begin
        req_ch.valid <= 1'b0;
        wait_quiet();
        case (phase)
          1: begin
            reg_write(REG_CAUSE, 32'hFFFF_FFFF);
            reg_write(REG_FAULT, 32'd1);
            reg_write(REG_INIT, 32'd1);
            reg_write(REG_COMM, 32'd1);
            reg_write(REG_HIT, 32'd1);
          end
          2: begin
            // zero periods: every timer always expired
            reg_write(REG_FAULT, 32'd0);
            reg_write(REG_INIT, 32'd0);
            reg_write(REG_COMM, 32'd0);
            reg_write(REG_HIT, 32'd0);
            reg_write(3'd5, 32'hFFFF_FFFF);              // no such register
            clock_ms = 32'hFFFF_FF00;                    // run across the wrap
          end
          3: begin
            reg_write(REG_CAUSE, 32'h5A);
            reg_write(REG_FAULT, 32'hFFFF);
            reg_write(REG_INIT, 32'hFFFF);
            reg_write(REG_COMM, 32'hFFFF);
            reg_write(REG_HIT, 32'hFFFF);
          end
          default: begin
            idle_on = 1'b0;                              // last part at full rate
            reg_write(REG_CAUSE, 32'd1);
            reg_write(REG_FAULT, 32'd100);
            reg_write(REG_INIT, 32'd500);
            reg_write(REG_COMM, 32'd300);
            reg_write(REG_HIT, 32'd100);
          end
        endcase
        if (phase == 1) tick(1'b1, 1'b1, 1'b0);         // reset cause despite busy layer
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_item();
    end

    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
